>>> src/hsf_pkg.sv
package hsf_pkg;

	// frame store geometry
	localparam int FRAME_BYTES = 8192;
	localparam int MEM_AW      = $clog2(FRAME_BYTES);

	// fixed field widths
	localparam int COORD_W = 8;
	localparam int BIT_W   = 2 * COORD_W;
	localparam int BYTE_W  = BIT_W - 3;
	localparam int RADDR_W = 13;
	localparam int DATA_W  = 8;

	// input and output bus widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ROW_WIDTH = 1'b0;
	localparam logic [COORD_W-1:0] ROW_WIDTH_RST = 8'd80;

	// item kinds carried in s_tuser
	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result status carried in m_tuser
	localparam logic ST_DONE   = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	localparam logic [DATA_W-1:0] FULL_BYTE = 8'hFF;

endpackage

>>> src/horizontal_span_fill_1bpp.sv
// One-bit-per-pixel frame store (8192 bytes, msb = leftmost pixel) with a span
// drawing engine. After reset the store is cleared byte by byte, during which
// no request is taken (register writes still are). A read request passes
// through S_RD and S_RDW to S_RES. A draw request passes through S_MUL and
// S_ADDR; a span that lies in one byte then has a single edge byte, while a
// longer span has an edge byte at each end and whole bytes between. The edge
// bytes go through read-modify-write (S_EDGE_RD, S_EDGE_WR) and the middle
// bytes are written one per cycle in S_FILL. A rejected draw goes straight to
// S_RES. A result waits in S_RES until the output register is free, and can
// wait on the output register while the next request is taken.
module horizontal_span_fill_1bpp (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hsf_pkg::PADDR_W-1:0]      paddr,
	input  logic [hsf_pkg::PDATA_W-1:0]      pwdata,
	output logic [hsf_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	// requests
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// x_start[7:0], x_end[15:8], row[23:16], read_address[36:24], zero fill
	input  logic [hsf_pkg::S_TDATA_W-1:0]    s_tdata,
	// op[0]
	input  logic                             s_tuser,
	// results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_data[7:0]
	output logic [hsf_pkg::M_TDATA_W-1:0]    m_tdata,
	// status[0]
	output logic                             m_tuser
);

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_RD      = 4'd2;
	localparam logic [3:0] S_RDW     = 4'd3;
	localparam logic [3:0] S_MUL     = 4'd4;
	localparam logic [3:0] S_ADDR    = 4'd5;
	localparam logic [3:0] S_EDGE_RD = 4'd6;
	localparam logic [3:0] S_EDGE_WR = 4'd7;
	localparam logic [3:0] S_FILL    = 4'd8;
	localparam logic [3:0] S_RES     = 4'd9;

	localparam int CW = hsf_pkg::COORD_W;
	localparam int DW = hsf_pkg::DATA_W;
	localparam int BW = hsf_pkg::BYTE_W;

	logic [3:0]                      state_q;
	logic [CW-1:0]                   row_width_q;
	logic [CW-1:0]                   xs_q, xe_q, row_q;
	logic [hsf_pkg::RADDR_W-1:0]     raddr_q;
	logic [hsf_pkg::BIT_W-1:0]       prod_q;
	logic [BW-1:0]                   cur_q, ebyte_q;
	logic [DW-1:0]                   mask_q, emask_q;
	logic                            last_q;
	logic                            res_status_q;
	logic [DW-1:0]                   res_data_q;
	logic                            m_tvalid_q;
	logic                            m_status_q;
	logic [DW-1:0]                   m_data_q;

	logic [DW-1:0]                   mem [hsf_pkg::FRAME_BYTES];
	logic [DW-1:0]                   rdata_q;
	logic                            mem_we;
	logic [hsf_pkg::MEM_AW-1:0]      mem_wa, mem_ra;
	logic [DW-1:0]                   mem_wd;

	logic                            s_req, cfg_wr;
	logic [CW-1:0]                   in_xs, in_xe, in_row;
	logic [hsf_pkg::RADDR_W-1:0]     in_raddr;
	logic                            span_bad;
	logic [hsf_pkg::BIT_W-1:0]       sbit, ebit;
	logic [BW-1:0]                   sbyte, ebyte, cur_nx;
	logic [DW-1:0]                   smask, emask;
	logic                            cur_in_store, raddr_in_store, res_load;

	// field unpacking
	assign in_xs    = s_tdata[7:0];
	assign in_xe    = s_tdata[15:8];
	assign in_row   = s_tdata[23:16];
	assign in_raddr = s_tdata[36:24];

	assign s_tready = (state_q == S_IDLE);
	assign s_req    = s_tvalid && s_tready;
	assign span_bad = (in_xs > in_xe) || (in_xe >= row_width_q);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == hsf_pkg::REG_ROW_WIDTH)
		? {{(hsf_pkg::PDATA_W-CW){1'b0}}, row_width_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= hsf_pkg::ROW_WIDTH_RST;
		end else if (cfg_wr && paddr[2] == hsf_pkg::REG_ROW_WIDTH) begin
			row_width_q <= pwdata[CW-1:0];
		end
	end

	// span address math
	assign sbit  = prod_q + {{CW{1'b0}}, xs_q};
	assign ebit  = prod_q + {{CW{1'b0}}, xe_q};
	assign sbyte = sbit[hsf_pkg::BIT_W-1:3];
	assign ebyte = ebit[hsf_pkg::BIT_W-1:3];
	assign smask = hsf_pkg::FULL_BYTE >> sbit[2:0];
	assign emask = hsf_pkg::FULL_BYTE << (3'd7 - ebit[2:0]);
	assign cur_nx = cur_q + 1'b1;

	assign cur_in_store   = {1'b0, cur_q} < (BW+1)'(hsf_pkg::FRAME_BYTES);
	assign raddr_in_store = {1'b0, raddr_q} < (hsf_pkg::RADDR_W+1)'(hsf_pkg::FRAME_BYTES);

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wd = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_EDGE_WR: begin
				mem_we = cur_in_store;
				mem_wd = rdata_q | mask_q;
			end
			S_FILL: begin
				mem_we = cur_in_store;
				mem_wd = hsf_pkg::FULL_BYTE;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end
	assign mem_wa = cur_q[hsf_pkg::MEM_AW-1:0];
	assign mem_ra = (state_q == S_RD) ? raddr_q[hsf_pkg::MEM_AW-1:0]
		: cur_q[hsf_pkg::MEM_AW-1:0];

	// frame store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	// request fields and span registers
	always_ff @(posedge clk) begin
		if (s_req) begin
			xs_q    <= in_xs;
			xe_q    <= in_xe;
			row_q   <= in_row;
			raddr_q <= in_raddr;
		end
		if (state_q == S_MUL) begin
			prod_q <= {{CW{1'b0}}, row_q} * {{CW{1'b0}}, row_width_q};
		end
		if (state_q == S_ADDR) begin
			ebyte_q <= ebyte;
			emask_q <= emask;
			mask_q  <= (sbyte == ebyte) ? (smask & emask) : smask;
		end else if ((state_q == S_EDGE_WR || state_q == S_FILL) && cur_nx == ebyte_q) begin
			mask_q  <= emask_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cur_q        <= '0;
			last_q       <= 1'b0;
			res_status_q <= hsf_pkg::ST_DONE;
			res_data_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cur_q <= cur_nx;
					if (cur_q == BW'(hsf_pkg::FRAME_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_req) begin
						res_status_q <= hsf_pkg::ST_DONE;
						res_data_q   <= '0;
						if (s_tuser == hsf_pkg::OP_READ) begin
							state_q <= S_RD;
						end else if (span_bad) begin
							res_status_q <= hsf_pkg::ST_REJECT;
							state_q      <= S_RES;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					res_data_q <= raddr_in_store ? rdata_q : '0;
					state_q    <= S_RES;
				end
				S_MUL: begin
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					cur_q   <= sbyte;
					last_q  <= (sbyte == ebyte);
					state_q <= S_EDGE_RD;
				end
				S_EDGE_RD: begin
					state_q <= S_EDGE_WR;
				end
				S_EDGE_WR: begin
					cur_q <= cur_nx;
					if (last_q) begin
						state_q <= S_RES;
					end else if (cur_nx == ebyte_q) begin
						last_q  <= 1'b1;
						state_q <= S_EDGE_RD;
					end else begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					cur_q <= cur_nx;
					if (cur_nx == ebyte_q) begin
						last_q  <= 1'b1;
						state_q <= S_EDGE_RD;
					end
				end
				S_RES: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	assign res_load = (state_q == S_RES) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_status_q <= res_status_q;
			m_data_q   <= res_data_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;

endmodule

>>> tb/frame_store_checker.sv
module frame_store_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port, watched for row width writes
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsf_pkg::PADDR_W-1:0]   paddr,
	input  logic [hsf_pkg::PDATA_W-1:0]   pwdata,
	input  logic                          pready,
	// request channel
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// x_start[7:0], x_end[15:8], row[23:16], read_address[36:24], zero fill
	input  logic [hsf_pkg::S_TDATA_W-1:0] s_tdata,
	// op[0]
	input  logic                          s_tuser,
	// result channel
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// read_data[7:0]
	input  logic [hsf_pkg::M_TDATA_W-1:0] m_tdata,
	// status[0]
	input  logic                          m_tuser,
	output int                            mismatches,
	output int                            outstanding,
	output int                            results_checked,
	output int                            spans_rejected
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW  = hsf_pkg::COORD_W;
	localparam int DW  = hsf_pkg::DATA_W;
	localparam int AW  = hsf_pkg::RADDR_W;
	localparam int PAW = hsf_pkg::PADDR_W;

	typedef struct packed {
		logic          status;
		logic [DW-1:0] read_data;
	} span_result_t;

	localparam logic [PAW-1:0] ROW_WIDTH_ADDR = PAW'(4 * hsf_pkg::REG_ROW_WIDTH);

	logic [DW-1:0]  frame_copy [hsf_pkg::FRAME_BYTES];
	logic [CW-1:0]  row_width;
	span_result_t   pending_results [$];
	span_result_t   oldest;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// bytes past the end of the store are dropped
	function automatic void or_into_store(input int idx, input logic [DW-1:0] mask);
		if (idx < hsf_pkg::FRAME_BYTES) begin
			frame_copy[idx] = frame_copy[idx] | mask;
		end
	endfunction

	// expected result of one request, updating the store copy for draws
	function automatic span_result_t apply_request(
		input logic          op,
		input logic [CW-1:0] x_start,
		input logic [CW-1:0] x_end,
		input logic [CW-1:0] row,
		input logic [AW-1:0] read_address
	);
		span_result_t  res;
		int            first_bit;
		int            last_bit;
		int            first_byte;
		int            last_byte;
		logic [DW-1:0] head_mask;
		logic [DW-1:0] tail_mask;

		res.status    = hsf_pkg::ST_DONE;
		res.read_data = '0;
		if (op == hsf_pkg::OP_READ) begin
			if (int'(read_address) < hsf_pkg::FRAME_BYTES) begin
				res.read_data = frame_copy[read_address];
			end
			return res;
		end
		// reversed span or span past the row end
		if (x_start > x_end || x_end >= row_width) begin
			res.status = hsf_pkg::ST_REJECT;
			return res;
		end
		first_bit  = int'(row) * int'(row_width) + int'(x_start);
		last_bit   = int'(row) * int'(row_width) + int'(x_end);
		first_byte = first_bit / 8;
		last_byte  = last_bit / 8;
		head_mask  = hsf_pkg::FULL_BYTE >> (first_bit % 8);
		tail_mask  = hsf_pkg::FULL_BYTE << (7 - last_bit % 8);
		if (first_byte == last_byte) begin
			or_into_store(first_byte, head_mask & tail_mask);
		end else begin
			or_into_store(first_byte, head_mask);
			for (int b = first_byte + 1; b < last_byte; b++) begin
				or_into_store(b, hsf_pkg::FULL_BYTE);
			end
			or_into_store(last_byte, tail_mask);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_copy[i]) begin
				frame_copy[i] = '0;
			end
			row_width = hsf_pkg::ROW_WIDTH_RST;
			pending_results.delete();
			mismatches      = 0;
			outstanding     = 0;
			results_checked = 0;
			spans_rejected  = 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready && paddr == ROW_WIDTH_ADDR) begin
				row_width = pwdata[CW-1:0];
			end
			// result against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: status %0b data %02h",
						m_tuser, m_tdata));
				end else begin
					oldest = pending_results.pop_front();
					if (m_tuser !== oldest.status) begin
						report_mismatch($sformatf("status %0b, expected %0b", m_tuser, oldest.status));
					end
					if (m_tdata !== oldest.read_data) begin
						report_mismatch($sformatf("read_data %02h, expected %02h",
							m_tdata, oldest.read_data));
					end
					results_checked++;
					if (oldest.status == hsf_pkg::ST_REJECT) begin
						spans_rejected++;
					end
				end
			end
			// accepted request
			if (s_tvalid && s_tready) begin
				pending_results.push_back(apply_request(s_tuser,
					s_tdata[CW-1:0],
					s_tdata[2*CW-1:CW],
					s_tdata[3*CW-1:2*CW],
					s_tdata[3*CW+AW-1:3*CW]));
			end
			outstanding = pending_results.size();
		end
	end

endmodule

>>> tb/horizontal_span_fill_1bpp_tb.sv
module horizontal_span_fill_1bpp_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW  = hsf_pkg::COORD_W;
	localparam int AW  = hsf_pkg::RADDR_W;
	localparam int PAW = hsf_pkg::PADDR_W;
	localparam int PDW = hsf_pkg::PDATA_W;
	localparam int TDW = hsf_pkg::S_TDATA_W;

	localparam int IDLE_LIMIT  = 50000;
	localparam int TAIL_CYCLES = 60;
	localparam int PHASE_ITEMS = 95;
	localparam logic [PAW-1:0] ROW_WIDTH_ADDR = PAW'(4 * hsf_pkg::REG_ROW_WIDTH);

	logic                          clk;
	logic                          arst_n   = 1'b0;
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [PAW-1:0]                paddr    = '0;
	logic [PDW-1:0]                pwdata   = '0;
	logic [PDW-1:0]                prdata;
	logic                          pready;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [TDW-1:0]                s_tdata  = '0;
	logic                          s_tuser  = hsf_pkg::OP_DRAW;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [hsf_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          m_tuser;

	int mismatches;
	int outstanding;
	int results_checked;
	int spans_rejected;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cur_width     = int'(hsf_pkg::ROW_WIDTH_RST);
	int last_span_byte = 0;
	int draws_sent    = 0;
	int reads_sent    = 0;
	int widths_used   = 0;

	horizontal_span_fill_1bpp dut (.*);

	frame_store_checker store_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.spans_rejected  (spans_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// one request, with random gaps ahead of it
	task automatic send_request(
		input logic          op,
		input logic [CW-1:0] x_start,
		input logic [CW-1:0] x_end,
		input logic [CW-1:0] row,
		input logic [AW-1:0] read_address
	);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= TDW'({read_address, row, x_end, x_start});
		do @(posedge clk); while (!s_tready);
		if (op == hsf_pkg::OP_DRAW) begin
			draws_sent++;
		end else begin
			reads_sent++;
		end
	endtask

	// hold off until every result is back
	task automatic drain_requests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	task automatic write_row_width(input int width);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ROW_WIDTH_ADDR;
		pwdata  <= PDW'(width);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		cur_width = width;
		widths_used++;
	endtask

	task automatic change_setting(input int width, input int send_pct, input int recv_pct);
		drain_requests();
		write_row_width(width);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// mostly legal spans, some rejects, reads near recent spans
	task automatic random_request();
		int            pick;
		logic [CW-1:0] x_start;
		logic [CW-1:0] x_end;
		logic [CW-1:0] row;
		logic [AW-1:0] read_address;

		pick         = $urandom_range(0, 99);
		x_start      = CW'($urandom_range(0, 255));
		x_end        = CW'($urandom_range(0, 255));
		row          = CW'($urandom_range(0, 255));
		read_address = AW'($urandom_range(0, hsf_pkg::FRAME_BYTES - 1));
		if (pick < 55) begin
			x_end   = CW'($urandom_range(0, cur_width - 1));
			x_start = CW'($urandom_range(0, int'(x_end)));
			last_span_byte = (int'(row) * cur_width + int'(x_start)) / 8;
			send_request(hsf_pkg::OP_DRAW, x_start, x_end, row, read_address);
		end else if (pick < 65) begin
			if ($urandom_range(0, 1) == 0) begin
				x_end   = CW'($urandom_range(0, 254));
				x_start = CW'($urandom_range(int'(x_end) + 1, 255));
			end else begin
				x_end = CW'($urandom_range(cur_width, 255));
			end
			send_request(hsf_pkg::OP_DRAW, x_start, x_end, row, read_address);
		end else if (pick < 82) begin
			read_address = AW'(last_span_byte + int'($urandom_range(0, 4)));
			send_request(hsf_pkg::OP_READ, x_start, x_end, row, read_address);
		end else begin
			send_request(hsf_pkg::OP_READ, x_start, x_end, row, read_address);
		end
	endtask

	// no progress on either channel for too long
	initial begin
		int idle_cycles;

		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset width
		write_row_width(int'(hsf_pkg::ROW_WIDTH_RST));
		send_idle_pct = 12;
		recv_idle_pct = 60;
		send_request(hsf_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF, 13'd0);
		send_request(hsf_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 13'h1FFF);
		send_request(hsf_pkg::OP_DRAW, 8'd0, 8'd0, 8'd0, 13'h1FFF);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd0);
		send_request(hsf_pkg::OP_DRAW, 8'd3, 8'd5, 8'd0, 13'd0);
		send_request(hsf_pkg::OP_DRAW, 8'd6, 8'd79, 8'd1, 13'h0AAA);
		send_request(hsf_pkg::OP_DRAW, 8'd0, 8'd79, 8'd255, 13'h1555);
		send_request(hsf_pkg::OP_DRAW, 8'd79, 8'd79, 8'd2, 13'd0);
		send_request(hsf_pkg::OP_DRAW, 8'd5, 8'd5, 8'd3, 13'd0);
		// reversed span and spans past the row end
		send_request(hsf_pkg::OP_DRAW, 8'd10, 8'd5, 8'd4, 13'd0);
		send_request(hsf_pkg::OP_DRAW, 8'd0, 8'd80, 8'd4, 13'd0);
		send_request(hsf_pkg::OP_DRAW, 8'd255, 8'd255, 8'd255, 13'h1FFF);
		send_request(hsf_pkg::OP_DRAW, 8'd0, 8'd255, 8'd0, 13'd0);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd0);
		send_request(hsf_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF, 13'd10);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd11);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd15);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd19);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd29);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd30);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd2550);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd2559);

		// widest rows, reaching the last used bytes of the store
		change_setting(255, 12, 60);
		send_request(hsf_pkg::OP_DRAW, 8'd0, 8'd254, 8'd255, 13'd0);
		send_request(hsf_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 13'd8159);
		repeat (PHASE_ITEMS) random_request();

		// one pixel per row
		change_setting(1, 60, 12);
		repeat (PHASE_ITEMS) random_request();

		change_setting($urandom_range(2, 254), 60, 12);
		repeat (PHASE_ITEMS) random_request();

		change_setting(37, 0, 0);
		repeat (PHASE_ITEMS) random_request();

		drain_requests();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d span draws and %0d byte reads over %0d row width settings",
			draws_sent, reads_sent, widths_used);
		$display("checked %0d results, %0d of them rejected spans, %0d mismatches",
			results_checked, spans_rejected, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
